// ===== sv/bbe_pkg.sv =====
// shared types, constants and helpers of the edge aware 3x3 box blur
package bbe_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // register field width and derived counter widths
    localparam int DIM_W = 12;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);

    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int SUM_W = 12;
    localparam int X_W   = 13;
    localparam int N_W   = 4;
    localparam int D_W   = 5;
    localparam int RCP_W = 16;
    localparam int RCP_SHIFT = 16;

    localparam int FIFO_DEPTH = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef pixel_t [2:0][2:0] window_t;

    // one output job handed from front to back
    typedef struct packed {
        window_t          win;
        logic [2:0][2:0]  mask;
        logic             last;
    } job_t;

    typedef enum logic {F_IDLE, F_UPD} front_state_t;
    typedef enum logic [2:0] {B_IDLE, B_SUM, B_MUL, B_FIX, B_OUT} back_state_t;

    // floor(2^16 / (2n)) for n in 1..9
    function automatic logic [RCP_W-1:0] recip(input logic [N_W-1:0] n);
        logic [RCP_W-1:0] r;
        case (n)
            4'd1:    r = 16'd32768;
            4'd2:    r = 16'd16384;
            4'd3:    r = 16'd10922;
            4'd4:    r = 16'd8192;
            4'd5:    r = 16'd6553;
            4'd6:    r = 16'd5461;
            4'd7:    r = 16'd4681;
            4'd8:    r = 16'd4096;
            4'd9:    r = 16'd3640;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/bbe_ram.sv =====
// generic single write, single read ram with registered read data
module bbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/bbe_front.sv =====
// front end: accepts items, owns line stores, window and counters, issues jobs
module bbe_front
    import bbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [CH_W-1:0]      blue_in,
    input  logic [CH_W-1:0]      green_in,
    input  logic [CH_W-1:0]      red_in,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output logic                 push,
    output job_t                 push_job,
    input  logic                 full
);

    front_state_t state_reg, state_next;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [CNT_W-1:0] total_reg;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [1:0]       in_row_reg, in_row_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] p_reg, p_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    window_t          win_reg, win_next;
    pixel_t           px_reg;

    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [2*DIM_W-1:0] area;
    logic               in_acc, cfg_acc, in_frame, drop, emit, go, last;
    pixel_t             older_rdata, newer_rdata, top, mid;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;
    assign in_stall  = (state_reg != F_IDLE);
    assign in_acc    = in_valid & ~in_stall;

    // effective frame size and pixel count
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        h_eff = height_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        area = w_eff * h_eff;
    end

    assign in_frame = (k_reg < total_reg);
    assign drop     = action & in_frame;

    // line stores
    bbe_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (go && (state_reg == F_UPD) && (in_row_reg != 2'd0)),
        .waddr (in_col_reg),
        .wdata (mid),
        .re    (in_acc),
        .raddr (in_col_reg),
        .rdata (older_rdata)
    );

    bbe_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (go && (state_reg == F_UPD)),
        .waddr (in_col_reg),
        .wdata (px_reg),
        .re    (in_acc),
        .raddr (in_col_reg),
        .rdata (newer_rdata)
    );

    assign top  = (in_row_reg == 2'd2) ? older_rdata : '0;
    assign mid  = (in_row_reg != 2'd0) ? newer_rdata : '0;
    assign emit = (k_reg >= CNT_W'(p_reg + CNT_W'(w_eff) + 1'b1));
    assign go   = ~emit | ~full;
    assign last = (CNT_W'(p_reg + 1'b1) >= total_reg);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // next state, window shift, counters and job
    always_comb
    begin
        state_next   = state_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        win_next     = win_reg;
        push         = 1'b0;
        push_job     = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (in_acc && !drop)
                    state_next = F_UPD;
            end
            F_UPD:
            begin
                if (go)
                begin
                    state_next = F_IDLE;
                    for (int r = 0; r < 3; r++)
                    begin
                        win_next[r][0] = win_reg[r][1];
                        win_next[r][1] = win_reg[r][2];
                    end
                    win_next[0][2] = top;
                    win_next[1][2] = mid;
                    win_next[2][2] = px_reg;
                    k_next = CNT_W'(k_reg + 1'b1);
                    if (DIM_W'(in_col_reg) + 1'b1 >= w_eff)
                    begin
                        in_col_next = '0;
                        if (in_row_reg != 2'd2)
                            in_row_next = in_row_reg + 1'b1;
                    end
                    else
                        in_col_next = in_col_reg + 1'b1;
                    if (emit)
                    begin
                        push          = 1'b1;
                        push_job.win  = win_next;
                        push_job.last = last;
                        for (int r = 0; r < 3; r++)
                        begin
                            for (int c = 0; c < 3; c++)
                            begin
                                push_job.mask[r][c] = 1'b1;
                            end
                        end
                        if (out_row_reg == '0)
                            push_job.mask[0] = 3'b000;
                        if (DIM_W'(out_row_reg) + 1'b1 >= h_eff)
                            push_job.mask[2] = 3'b000;
                        if (out_col_reg == '0)
                        begin
                            for (int r = 0; r < 3; r++)
                                push_job.mask[r][0] = 1'b0;
                        end
                        if (DIM_W'(out_col_reg) + 1'b1 >= w_eff)
                        begin
                            for (int r = 0; r < 3; r++)
                                push_job.mask[r][2] = 1'b0;
                        end
                        if (last)
                        begin
                            in_col_next  = '0;
                            in_row_next  = '0;
                            k_next       = '0;
                            p_next       = '0;
                            out_col_next = '0;
                            out_row_next = '0;
                        end
                        else
                        begin
                            p_next = CNT_W'(p_reg + 1'b1);
                            if (DIM_W'(out_col_reg) + 1'b1 >= w_eff)
                            begin
                                out_col_next = '0;
                                out_row_next = out_row_reg + 1'b1;
                            end
                            else
                                out_col_next = out_col_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // counters, window and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RESET_WIDTH;
            height_reg  <= RESET_HEIGHT;
            total_reg   <= CNT_W'(RESET_WIDTH) * CNT_W'(RESET_HEIGHT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            k_reg       <= '0;
            p_reg       <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            win_reg     <= '0;
        end
        else
        begin
            total_reg <= CNT_W'(area);
            if (cfg_acc)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg <= cfg_data;
                else if (cfg_index == REG_FRAME_HEIGHT)
                    height_reg <= cfg_data;
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                k_reg       <= '0;
                p_reg       <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                win_reg     <= '0;
            end
            else
            begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                k_reg       <= k_next;
                p_reg       <= p_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
                win_reg     <= win_next;
            end
        end
    end

    // captured pixel, zero once the frame is complete
    always_ff @(posedge clk)
    begin
        if (in_acc)
            px_reg <= in_frame ? {red_in, green_in, blue_in} : '0;
    end

endmodule

// ===== sv/bbe_fifo.sv =====
// short job queue between front and back
module bbe_fifo
    import bbe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    job_t                 entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]       count_reg;

    assign full    = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== sv/bbe_back.sv =====
// back end: neighborhood sums, rounded mean by reciprocal and output register
module bbe_back
    import bbe_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    output logic            pop,
    input  job_t            pop_job,
    input  logic            empty,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [CH_W-1:0] blue_out,
    output logic [CH_W-1:0] green_out,
    output logic [CH_W-1:0] red_out,
    output logic            frame_end
);

    back_state_t state_reg, state_next;

    job_t                  job_reg;
    logic [2:0][X_W-1:0]   x_reg;
    logic [2:0][CH_W-1:0]  q0_reg;
    logic [2:0][CH_W-1:0]  res_reg;
    logic [N_W-1:0]        n_reg;
    logic                  last_reg;

    logic [2:0][SUM_W-1:0]        sum;
    logic [N_W-1:0]               n;
    logic [2:0][X_W+RCP_W-1:0]    prod;
    logic [D_W-1:0]               d;
    logic [2:0][X_W-1:0]          rem;
    logic [2:0][CH_W-1:0]         q;

    assign pop       = (state_reg == B_IDLE) && !empty;
    assign out_valid = (state_reg == B_OUT);
    assign blue_out  = res_reg[0];
    assign green_out = res_reg[1];
    assign red_out   = res_reg[2];
    assign frame_end = last_reg;
    assign d         = {n_reg, 1'b0};

    // masked sums over the window
    always_comb
    begin
        sum = '0;
        n   = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (job_reg.mask[r][c])
                begin
                    n = n + 1'b1;
                    for (int ch = 0; ch < 3; ch++)
                        sum[ch] = sum[ch] + SUM_W'(job_reg.win[r][c][ch*CH_W +: CH_W]);
                end
            end
        end
    end

    // quotient estimate and one step correction
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = x_reg[ch] * recip(n_reg);
            rem[ch]  = X_W'(x_reg[ch] - X_W'(q0_reg[ch]) * X_W'(d));
            q[ch]    = (rem[ch] >= X_W'(d)) ? q0_reg[ch] + 1'b1 : q0_reg[ch];
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!empty) state_next = B_SUM;
            B_SUM:   state_next = B_MUL;
            B_MUL:   state_next = B_FIX;
            B_FIX:   state_next = B_OUT;
            B_OUT:   if (!out_stall) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= pop_job;
        if (state_reg == B_SUM)
        begin
            n_reg    <= n;
            last_reg <= job_reg.last;
            for (int ch = 0; ch < 3; ch++)
                x_reg[ch] <= X_W'({sum[ch], 1'b0} + n);
        end
        if (state_reg == B_MUL)
        begin
            for (int ch = 0; ch < 3; ch++)
                q0_reg[ch] <= prod[ch][RCP_SHIFT +: CH_W];
        end
        if (state_reg == B_FIX)
            res_reg <= q;
    end

endmodule

// ===== sv/box_blur_3x3_edge_aware_top.sv =====
// path: a completing pixel passes F_UPD, the job queue and B_SUM, B_MUL, B_FIX, B_OUT
// input: a pixel or closing drain tick stalls the front in F_UPD; a mid-frame drain does not
// the back pops a new job only from B_IDLE after B_OUT, which sets the sustained rate
// reset: counters and window clear, frame size returns to 640 x 480, line stores keep
// their contents and are only read where written in the current frame
module box_blur_3x3_edge_aware_top
    import bbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [CH_W-1:0]      blue_in,
    input  logic [CH_W-1:0]      green_in,
    input  logic [CH_W-1:0]      red_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CH_W-1:0]      blue_out,
    output logic [CH_W-1:0]      green_out,
    output logic [CH_W-1:0]      red_out,
    output logic                 frame_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    logic push, full, pop, empty;
    job_t push_job, pop_job;

    // front end
    bbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .blue_in   (blue_in),
        .green_in  (green_in),
        .red_in    (red_in),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_job  (push_job),
        .full      (full)
    );

    // job queue
    bbe_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    // back end
    bbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_job   (pop_job),
        .empty     (empty),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .blue_out  (blue_out),
        .green_out (green_out),
        .red_out   (red_out),
        .frame_end (frame_end)
    );

endmodule

// ===== sv/bbe_checker.sv =====
// port level checks for the box blur top, attached by bind
module bbe_checker
    import bbe_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 action,
    input logic [CH_W-1:0]      blue_in,
    input logic [CH_W-1:0]      green_in,
    input logic [CH_W-1:0]      red_in,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [CH_W-1:0]      blue_out,
    input logic [CH_W-1:0]      green_out,
    input logic [CH_W-1:0]      red_out,
    input logic                 frame_end,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [DIM_W-1:0]     cfg_data
);

    // stalled result stays offered with the same payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({blue_out, green_out, red_out, frame_end}))
        else $error("stalled result changed");

    // a pixel transfer always occupies the front for its update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !action |=> in_stall)
        else $error("front took a pixel without update cycle");

    // the update cycle ends unless a job must go into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_valid && !$past(out_valid) |=> !in_stall || $past(in_stall))
        else $error("front stall persisted without cause");

    // configuration port is always open
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration transfer refused");

endmodule

bind box_blur_3x3_edge_aware_top bbe_checker u_bbe_checker (.*);

// ===== dv/bbe_tb_pkg.sv =====
// item kinds shared by the box blur testbench files
package bbe_tb_pkg;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

endpackage

// ===== dv/box_blur_3x3_edge_aware_checker.sv =====
// channel monitor, blur predictor and result comparison for the box blur
module box_blur_3x3_edge_aware_checker
    import bbe_pkg::*;
    import bbe_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 action,
    input  logic [CH_W-1:0]      blue_in,
    input  logic [CH_W-1:0]      green_in,
    input  logic [CH_W-1:0]      red_in,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [CH_W-1:0]      blue_out,
    input  logic [CH_W-1:0]      green_out,
    input  logic [CH_W-1:0]      red_out,
    input  logic                 frame_end,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output int unsigned          fail_count,
    output int unsigned          pending_count,
    output int unsigned          blurred_count
);

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            last;
    } blurred_px_t;

    blurred_px_t blurred_q[$];

    pixel_t          upper_line[MAX_WIDTH];
    pixel_t          lower_line[MAX_WIDTH];
    pixel_t          win[3][3];
    int unsigned     in_col, in_row, out_col, out_row;
    logic [DIM_W-1:0] width_reg, height_reg;

    assign pending_count = blurred_q.size();

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_frame();
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // advance the blur state by one accepted item, queue the pixel it completes
    function automatic void blur_item(logic act, pixel_t px_in);
        int unsigned w, h, total, k, p, n, sb, sg, sr;
        pixel_t      px, above, middle;
        blurred_px_t res;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        total = w * h;
        k = in_row * w + in_col;
        // drain tick mid frame is ignored
        if (act == ACT_DRAIN && k < total)
            return;
        px = (k < total) ? px_in : '0;
        above  = (in_row >= 2) ? upper_line[in_col] : '0;
        middle = (in_row >= 1) ? lower_line[in_col] : '0;
        if (in_row >= 1)
            upper_line[in_col] = middle;
        lower_line[in_col] = px;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = above;
        win[1][2] = middle;
        win[2][2] = px;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        p = out_row * w + out_col;
        if (k < p + w + 1)
            return;
        n = 0; sb = 0; sg = 0; sr = 0;
        for (int r = 0; r < 3; r++)
        begin
            if (r == 0 && out_row < 1) continue;
            if (r == 2 && out_row + 1 >= h) continue;
            for (int c = 0; c < 3; c++)
            begin
                if (c == 0 && out_col < 1) continue;
                if (c == 2 && out_col + 1 >= w) continue;
                sb += win[r][c][7:0];
                sg += win[r][c][15:8];
                sr += win[r][c][23:16];
                n++;
            end
        end
        // half up rounding of the mean
        res.blue  = (2 * sb + n) / (2 * n);
        res.green = (2 * sg + n) / (2 * n);
        res.red   = (2 * sr + n) / (2 * n);
        res.last  = (p + 1 >= total);
        blurred_q.push_back(res);
        if (res.last)
            clear_frame();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        blurred_px_t want;
        if (!rst_n)
        begin
            blurred_q.delete();
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            clear_frame();
            fail_count = 0;
            blurred_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                blurred_count++;
                if (blurred_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected output transfer b=%0d g=%0d r=%0d end=%0b",
                             $time, blue_out, green_out, red_out, frame_end);
                end
                else
                begin
                    want = blurred_q.pop_front();
                    if (want.blue !== blue_out || want.green !== green_out ||
                        want.red !== red_out || want.last !== frame_end)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected b=%0d g=%0d r=%0d end=%0b",
                                 $time, want.blue, want.green, want.red, want.last);
                        $display("%0t:          actual   b=%0d g=%0d r=%0d end=%0b",
                                 $time, blue_out, green_out, red_out, frame_end);
                    end
                end
            end
            if (in_valid && !in_stall)
                blur_item(action, {red_in, green_in, blue_in});
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                clear_frame();
            end
        end
    end

endmodule

// ===== dv/tb_box_blur_3x3_edge_aware_top.sv =====
// stimulus and verdict for the edge aware 3x3 box blur
module tb_box_blur_3x3_edge_aware_top;
    import bbe_pkg::*;
    import bbe_tb_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 action;
    logic [CH_W-1:0]      blue_in, green_in, red_in;
    logic                 out_valid;
    logic                 out_stall;
    logic [CH_W-1:0]      blue_out, green_out, red_out;
    logic                 frame_end;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    int unsigned fail_count, pending_count, blurred_count;
    int unsigned items_sent, frames_sent, burst_left, idle_cycles;
    bit          hold_req;

    box_blur_3x3_edge_aware_top dut (.*);

    box_blur_3x3_edge_aware_checker chk (.*);

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int unsigned mode, span;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (int i = 0; i < span; i++)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    out_stall <= 1'b1;
                    for (int j = 0; j < 400; j++)
                        @(posedge clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    2: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one input transfer, in bursts with random gaps
    task automatic push_item(input logic act, input logic [CH_W-1:0] b, g, r);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        action   <= act;
        blue_in  <= b;
        green_in <= g;
        red_in   <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CH_W-1:0] pick_channel(int unsigned style);
        case (style)
            0: return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
            1: return 8'd255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // one full frame: pixels with stray drain ticks, then closing drains or pixels
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned style, input bit noisy);
        for (int i = 0; i < w * h; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                push_item(ACT_DRAIN, pick_channel(2), pick_channel(2), pick_channel(2));
            push_item(ACT_PIXEL, pick_channel(style), pick_channel(style),
                      pick_channel(style));
        end
        for (int i = 0; i <= w; i++)
        begin
            if (noisy && $urandom_range(0, 3) == 0)
                push_item(ACT_PIXEL, pick_channel(2), pick_channel(2), pick_channel(2));
            else
                push_item(ACT_DRAIN, pick_channel(2), pick_channel(2), pick_channel(2));
        end
        frames_sent++;
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        settle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    initial
    begin
        int unsigned w, h;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_PIXEL;
        blue_in = '0;
        green_in = '0;
        red_in = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        hold_req = 1'b0;
        items_sent = 0;
        frames_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single pixel, zero sizes clamp, full scale values, thin frames
        set_frame(12'd1, 12'd1);
        run_frame(1, 1, 1, 1'b0);
        set_frame(12'd0, 12'd0);
        run_frame(1, 1, 0, 1'b1);
        set_frame(12'd3, 12'd3);
        run_frame(3, 3, 1, 1'b0);
        set_frame(12'd2, 12'd1);
        run_frame(2, 1, 0, 1'b1);
        set_frame(12'd1, 12'd3);
        run_frame(1, 3, 2, 1'b1);

        // random frame sizes, all small (up to 12 x 8), sometimes reusing the last size
        while (items_sent < 1700)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0 || frames_sent < 8)
                set_frame(w, h);
            else
            begin
                w = chk.width_reg;
                h = chk.height_reg;
            end
            if (frames_sent == 12)
                hold_req = 1'b1;
            run_frame(w, h, $urandom_range(0, 3), 1'b1);
        end

        settle();
        $display("covered %0d input items over %0d frames, %0d blurred pixels checked",
                 items_sent, frames_sent, blurred_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
